// ----- sv/kre_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kre_pkg
// Shared types and constants for the keystroke to remote input event block.
// ----------------------------------------------------------------------------
package kre_pkg;

    // Configuration register indexes
    localparam int unsigned REG_INDEX_W = 3;
    localparam logic [REG_INDEX_W-1:0] REG_COMMAND_KEY = 3'd0;
    localparam logic [REG_INDEX_W-1:0] REG_MOUSE_KEYS  = 3'd1;
    localparam logic [REG_INDEX_W-1:0] REG_MOUSE_STEP  = 3'd2;
    localparam logic [REG_INDEX_W-1:0] REG_SCREEN_COLS = 3'd3;
    localparam logic [REG_INDEX_W-1:0] REG_SCREEN_ROWS = 3'd4;
    localparam int unsigned CFG_DATA_W = 56;

    // Result kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_KEY     = 2'd1;
    localparam logic [1:0] KIND_POINTER = 2'd2;
    localparam logic [1:0] KIND_QUIT    = 2'd3;

    // Keysyms
    localparam logic [15:0] KEYSYM_BACKSPACE = 16'hff08;
    localparam logic [15:0] KEYSYM_TAB       = 16'hff09;
    localparam logic [15:0] KEYSYM_ESCAPE    = 16'hff1b;
    localparam logic [15:0] KEYSYM_RETURN    = 16'hff0d;
    localparam logic [15:0] KEYSYM_SHIFT_L   = 16'hffe1;
    localparam logic [15:0] KEYSYM_CONTROL_L = 16'hffe3;

    // Terminal bytes
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_CR  = 8'h0d;
    localparam logic [7:0] BYTE_ESC = 8'h1b;
    localparam logic [7:0] BYTE_DEL = 8'h7f;
    localparam logic [7:0] BYTE_ETX = 8'h03;
    localparam logic [7:0] BYTE_Q   = 8'h71;  // 'q'
    localparam logic [7:0] BYTE_I   = 8'h69;  // 'i'
    localparam logic [7:0] BYTE_R   = 8'h72;  // 'r'
    localparam logic [7:0] BYTE_L   = 8'h4c;  // 'L'

    // Pointer position limits
    localparam logic signed [17:0] POS_MAX = 18'sd65535;
    localparam logic signed [17:0] POS_MIN = -18'sd65535;

    // Queue between classifier and event generator
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = 1;

    typedef struct packed {
        logic [7:0]  command_key;
        logic [55:0] mouse_keys;
        logic [7:0]  mouse_step;
        logic [15:0] screen_cols;
        logic [15:0] screen_rows;
    } cfg_t;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_QUIT,
        JOB_KEY,
        JOB_PTR
    } job_op_t;

    typedef enum logic [1:0] {
        MOD_NONE,
        MOD_SHIFT,
        MOD_CTRL
    } mod_t;

    // One classified item, ready to be expanded into events
    typedef struct packed {
        job_op_t           op;
        logic [15:0]       keysym;
        mod_t              modifier;
        logic signed [17:0] pos_x;
        logic signed [17:0] pos_y;
        logic [2:0]        btn;
        logic              redraw;
    } job_t;

endpackage
`default_nettype wire

// ----- sv/kre_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kre_front
// Classifier: takes one byte, updates mode and pointer, pushes a job.
// ----------------------------------------------------------------------------
module kre_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     key_byte,
    input  wire kre_pkg::cfg_t  cfg,
    input  wire logic           q_full,
    output logic                push,
    output kre_pkg::job_t       job
);

    localparam logic [2:0] MK_LEFT  = 3'd0;
    localparam logic [2:0] MK_DOWN  = 3'd1;
    localparam logic [2:0] MK_UP    = 3'd2;
    localparam logic [2:0] MK_RIGHT = 3'd3;
    localparam logic [2:0] MK_BTN1  = 3'd4;
    localparam logic [2:0] MK_BTN2  = 3'd5;

    logic               mode_reg, mode_next;
    logic signed [17:0] col_reg, col_next;
    logic signed [17:0] row_reg, row_next;

    logic               hit;
    logic [2:0]         hit_idx;
    logic signed [17:0] step_ext, base, sum, moved;
    logic [15:0]        k;
    logic               accept;

    function automatic logic needs_shift(input logic [7:0] c);
        return (c inside {[8'h41:8'h5a]}) ||
               (c inside {8'h3a, 8'h22, 8'h3c, 8'h3e, 8'h3f, 8'h7b, 8'h7d,
                          8'h7c, 8'h2b, 8'h5f, 8'h28, 8'h29, 8'h2a, 8'h26,
                          8'h5e, 8'h25, 8'h24, 8'h23, 8'h40, 8'h21, 8'h7e});
    endfunction

    assign in_ready = ~q_full;
    assign accept   = in_valid & ~q_full;
    assign push     = accept;

    // Mouse key match, lowest index wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 6; i >= 0; i--) begin
            if (cfg.mouse_keys[8*i +: 8] == key_byte) begin
                hit     = 1'b1;
                hit_idx = 3'(i);
            end
        end
    end

    // Saturating pointer move, one shared adder
    always_comb begin
        step_ext = $signed({10'd0, cfg.mouse_step});
        base     = (hit_idx == MK_LEFT || hit_idx == MK_RIGHT) ? col_reg : row_reg;
        sum      = (hit_idx == MK_LEFT || hit_idx == MK_UP) ? base - step_ext
                                                             : base + step_ext;
        if (sum > kre_pkg::POS_MAX) begin
            moved = kre_pkg::POS_MAX;
        end else if (sum < kre_pkg::POS_MIN) begin
            moved = kre_pkg::POS_MIN;
        end else begin
            moved = sum;
        end
    end

    always_comb begin
        mode_next = mode_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        k         = '0;
        job       = '0;
        job.op       = kre_pkg::JOB_NONE;
        job.modifier = kre_pkg::MOD_NONE;

        if (!mode_reg) begin
            if (key_byte == kre_pkg::BYTE_BS || key_byte == kre_pkg::BYTE_DEL) begin
                k = kre_pkg::KEYSYM_BACKSPACE;
            end else if (key_byte == kre_pkg::BYTE_TAB) begin
                k = kre_pkg::KEYSYM_TAB;
            end else if (key_byte == kre_pkg::BYTE_ESC) begin
                k = kre_pkg::KEYSYM_ESCAPE;
            end else if (key_byte == kre_pkg::BYTE_CR) begin
                k = kre_pkg::KEYSYM_RETURN;
            end else if (key_byte == cfg.command_key) begin
                mode_next = 1'b1;
            end else begin
                k = {8'd0, key_byte};
            end
        end else if (hit) begin
            job.op = kre_pkg::JOB_PTR;
            case (hit_idx)
                MK_LEFT, MK_RIGHT: col_next = moved;
                MK_DOWN, MK_UP:    row_next = moved;
                MK_BTN1:           job.btn  = 3'b001;
                MK_BTN2:           job.btn  = 3'b010;
                default:           job.btn  = 3'b100;
            endcase
        end else if (key_byte == cfg.command_key) begin
            k = {8'd0, key_byte};
        end else if (key_byte == kre_pkg::BYTE_Q || key_byte == kre_pkg::BYTE_I) begin
            mode_next = 1'b0;
        end else if (key_byte == kre_pkg::BYTE_ETX) begin
            job.op = kre_pkg::JOB_QUIT;
        end else if (key_byte == kre_pkg::BYTE_R || key_byte == kre_pkg::BYTE_L) begin
            job.redraw = 1'b1;
        end

        job.pos_x = col_next;
        job.pos_y = row_next;

        // Modifier is decided anew for each byte; ctrl overrides shift
        if (k != '0) begin
            job.op     = kre_pkg::JOB_KEY;
            job.keysym = k;
            if (k[15:8] == 8'd0 && needs_shift(k[7:0])) begin
                job.modifier = kre_pkg::MOD_SHIFT;
            end
            if (k >= 16'd1 && k <= 16'd26) begin
                job.keysym   = k + 16'h0060;
                job.modifier = kre_pkg::MOD_CTRL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            col_reg  <= '0;
            row_reg  <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/kre_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kre_queue
// Two-entry job queue between classifier and event generator.
// ----------------------------------------------------------------------------
module kre_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire kre_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output kre_pkg::job_t      head_job,
    output logic               head_valid
);

    localparam int unsigned CW = kre_pkg::QUEUE_AW + 1;

    kre_pkg::job_t                 mem [kre_pkg::QUEUE_DEPTH];
    logic [kre_pkg::QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [kre_pkg::QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic                          do_push, do_pop;

    assign full       = (count_reg == CW'(kre_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// ----- sv/kre_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kre_back
// Event generator: expands the head job into one to four result items.
// ----------------------------------------------------------------------------
module kre_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire kre_pkg::cfg_t cfg,
    input  wire kre_pkg::job_t head_job,
    input  wire logic          head_valid,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [1:0]         out_kind,
    output logic [15:0]        out_keysym,
    output logic               out_key_down,
    output logic [15:0]        out_pointer_x,
    output logic [15:0]        out_pointer_y,
    output logic [2:0]         out_button_mask,
    output logic               out_redraw,
    output logic               out_last
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] keysym;
        logic        key_down;
        logic [15:0] pointer_x;
        logic [15:0] pointer_y;
        logic [2:0]  button_mask;
        logic        redraw;
        logic        last;
    } res_t;

    logic [1:0]  step_reg, step_next;
    logic        valid_reg, valid_next;
    res_t        res_reg, res;
    logic        load;
    logic [15:0] mod_sym, px, py;

    // max(0, min(size-1, pos)); a size of zero gives zero
    function automatic logic [15:0] clamp_pos(input logic signed [17:0] pos,
                                              input logic [15:0] size);
        logic [15:0] r;
        if (pos[17]) begin
            r = '0;
        end else if (pos[16:0] >= {1'b0, size}) begin
            r = (size == 16'd0) ? 16'd0 : size - 16'd1;
        end else begin
            r = pos[15:0];
        end
        return r;
    endfunction

    always_comb begin
        px      = clamp_pos(head_job.pos_x, cfg.screen_cols);
        py      = clamp_pos(head_job.pos_y, cfg.screen_rows);
        mod_sym = (head_job.modifier == kre_pkg::MOD_SHIFT) ? kre_pkg::KEYSYM_SHIFT_L
                                                            : kre_pkg::KEYSYM_CONTROL_L;
        res      = '0;
        res.last = 1'b1;
        case (head_job.op)
            kre_pkg::JOB_NONE: begin
                res.kind   = kre_pkg::KIND_NONE;
                res.redraw = head_job.redraw;
            end
            kre_pkg::JOB_QUIT: begin
                res.kind = kre_pkg::KIND_QUIT;
            end
            kre_pkg::JOB_KEY: begin
                res.kind = kre_pkg::KIND_KEY;
                if (head_job.modifier != kre_pkg::MOD_NONE) begin
                    // modifier down, key down, key up, modifier up
                    case (step_reg)
                        2'd0: begin
                            res.keysym   = mod_sym;
                            res.key_down = 1'b1;
                            res.last     = 1'b0;
                        end
                        2'd1: begin
                            res.keysym   = head_job.keysym;
                            res.key_down = 1'b1;
                            res.last     = 1'b0;
                        end
                        2'd2: begin
                            res.keysym = head_job.keysym;
                            res.last   = 1'b0;
                        end
                        default: begin
                            res.keysym = mod_sym;
                        end
                    endcase
                end else begin
                    res.keysym = head_job.keysym;
                    case (step_reg)
                        2'd0: begin
                            res.key_down = 1'b1;
                            res.last     = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            kre_pkg::JOB_PTR: begin
                res.kind      = kre_pkg::KIND_POINTER;
                res.pointer_x = px;
                res.pointer_y = py;
                if (head_job.btn != 3'd0) begin
                    // move, press, release
                    case (step_reg)
                        2'd0: res.last = 1'b0;
                        2'd1: begin
                            res.button_mask = head_job.btn;
                            res.last        = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign load = head_valid & (~valid_reg | out_ready);
    assign pop  = load & res.last;

    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            step_next  = res.last ? 2'd0 : step_reg + 2'd1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign out_valid       = valid_reg;
    assign out_kind        = res_reg.kind;
    assign out_keysym      = res_reg.keysym;
    assign out_key_down    = res_reg.key_down;
    assign out_pointer_x   = res_reg.pointer_x;
    assign out_pointer_y   = res_reg.pointer_y;
    assign out_button_mask = res_reg.button_mask;
    assign out_redraw      = res_reg.redraw;
    assign out_last        = res_reg.last;

endmodule
`default_nettype wire

// ----- sv/keystroke_to_remote_input_events.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// keystroke_to_remote_input_events
// The first result item passes the queue write on the taking edge and then
// the output register load, which waits while that register is full and m_tready is low.
// Throughput: 1 to 4 result items per input item, one per cycle while m_tready
// is high, set by the single output register; an input item is taken every
// cycle while the two-entry job queue has room.
// Reset (aresetn low, synchronous): normal mode, pointer at 0,0, queue and
// output emptied, registers back to their defaults.
// ----------------------------------------------------------------------------
//
// Structure:
//   kre_front  - decodes the terminal byte against the current mode and the
//                configured keys, moves the kept pointer (saturating), and
//                pushes one job per byte.
//   kre_queue  - two-entry job queue, so the front keeps taking bytes while
//                the back drains a multi-event job.
//   kre_back   - walks the head job through its events (shift/ctrl wrap,
//                button press/release), clamps the pointer to the screen and
//                loads the output register.
//
module keystroke_to_remote_input_events (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] key_byte

    // Result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,    // [15:0] keysym, [16] key_down,
                                         // [32:17] pointer_x, [48:33] pointer_y,
                                         // [51:49] button_mask,
                                         // [52] redraw_request, [55:53] zero
    output logic [1:0]       m_tuser,    // [1:0] kind
    output logic             m_tlast,

    // Configuration writes
    input  wire logic                            cfg_we,
    input  wire logic [kre_pkg::REG_INDEX_W-1:0] cfg_index,
    input  wire logic [kre_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    // Configuration registers
    kre_pkg::cfg_t cfg_reg;

    // Front to queue
    logic          push;
    kre_pkg::job_t push_job;
    logic          q_full;

    // Queue to back
    logic          pop;
    kre_pkg::job_t head_job;
    logic          head_valid;

    // Back outputs
    logic [1:0]    out_kind;
    logic [15:0]   out_keysym;
    logic          out_key_down;
    logic [15:0]   out_pointer_x;
    logic [15:0]   out_pointer_y;
    logic [2:0]    out_button_mask;
    logic          out_redraw;

    // Register writes land at once; indexes past the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.command_key <= 8'd0;
            cfg_reg.mouse_keys  <= 56'd0;
            cfg_reg.mouse_step  <= 8'd1;
            cfg_reg.screen_cols <= 16'd640;
            cfg_reg.screen_rows <= 16'd480;
        end else if (cfg_we) begin
            case (cfg_index)
                kre_pkg::REG_COMMAND_KEY: cfg_reg.command_key <= cfg_wdata[7:0];
                kre_pkg::REG_MOUSE_KEYS:  cfg_reg.mouse_keys  <= cfg_wdata[55:0];
                kre_pkg::REG_MOUSE_STEP:  cfg_reg.mouse_step  <= cfg_wdata[7:0];
                kre_pkg::REG_SCREEN_COLS: cfg_reg.screen_cols <= cfg_wdata[15:0];
                kre_pkg::REG_SCREEN_ROWS: cfg_reg.screen_rows <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    kre_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .key_byte (s_tdata),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (push),
        .job      (push_job)
    );

    kre_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_job   (head_job),
        .head_valid (head_valid)
    );

    kre_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .head_job        (head_job),
        .head_valid      (head_valid),
        .pop             (pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_kind        (out_kind),
        .out_keysym      (out_keysym),
        .out_key_down    (out_key_down),
        .out_pointer_x   (out_pointer_x),
        .out_pointer_y   (out_pointer_y),
        .out_button_mask (out_button_mask),
        .out_redraw      (out_redraw),
        .out_last        (m_tlast)
    );

    // Pack the result fields, lowest field first
    assign m_tdata = {3'd0, out_redraw, out_button_mask, out_pointer_y,
                      out_pointer_x, out_key_down, out_keysym};
    assign m_tuser = out_kind;

endmodule
`default_nettype wire
